/* rtl/rbfh_pkg.sv */
// Shared types, constants and saturation helpers for the ray / box-face hit block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbfh_pkg;

    localparam int TABLE_DEPTH = 106;
    localparam int VERT_BASE   = 16;
    localparam int NORM_BASE   = 88;
    localparam int MAT_WORDS   = 16;
    localparam int FACE_WORDS  = 15;
    localparam int VERT_WORDS  = 12;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [35:0] DIST_MAX = 36'hF_FFFF_FFFF;

    typedef struct packed {
        logic               kind;
        logic [6:0]         table_addr;
        logic signed [31:0] table_value;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } cmd_beat_t;

    typedef struct packed {
        logic        hit;
        logic [35:0] dist_sq;
        logic [2:0]  face_index;
    } res_beat_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } div_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] d;
        d = 64'(a) - 64'(b);
        return sat32(d);
    endfunction

    // corner j, axis a -> slot j*3+a
    function automatic logic [3:0] idx3(input logic [1:0] j, input logic [1:0] a);
        return {1'b0, j, 1'b0} + {2'b00, j} + {2'b00, a};
    endfunction

endpackage

`default_nettype wire

/* rtl/rbfh_cmd_if.sv */
// Input channel: valid/ready handshake carrying one load or query beat.
// Depends on rbfh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rbfh_cmd_if import rbfh_pkg::*;;
    logic      valid;
    logic      ready;
    cmd_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rbfh_res_if.sv */
// Output channel: valid/ready handshake carrying one result beat.
// Depends on rbfh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rbfh_res_if import rbfh_pkg::*;;
    logic      valid;
    logic      ready;
    res_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rbfh_table.sv */
// Geometry table: 106 x 32 single-port-write, registered-read memory.
// Depends on rbfh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbfh_table import rbfh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [6:0]         waddr,
    input  wire logic signed [31:0] wdata,
    input  wire logic [6:0]         raddr,
    output logic signed [31:0]      rdata
);

    logic signed [31:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/rbfh_mul.sv */
// Shared fixed-point multiplier: registered floor((a*b) / 2^FRAC_BITS).
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module rbfh_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [63:0]      prod
);

    logic signed [63:0] full;

    assign full = 64'(a) * 64'(b);

    always_ff @(posedge clk)
    begin
        prod <= full >>> FRAC_BITS;
    end

endmodule

`default_nettype wire

/* rtl/rbfh_div.sv */
// Restoring divider, one quotient bit per cycle: floor(n * 2^FRAC_BITS / d),
// saturated to 2^31-1. Depends on rbfh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbfh_div import rbfh_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] n,
    input  wire logic [63:0] d,
    output div_res_t         res
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int RW = 66;
    localparam int QB = 31;

    typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN} dstate_t;

    dstate_t           state_reg;
    logic [RW-1:0]     r_reg;
    logic [QB-1:0]     lo_reg;
    logic [63:0]       d_reg;
    logic [QB-1:0]     q_reg;
    logic [4:0]        cnt_reg;
    logic              done_reg;
    logic [31:0]       quot_reg;

    logic [NW-1:0]     nsh;
    logic [RW-1:0]     r2;
    logic [RW-1:0]     dx;
    logic              qbit;

    assign nsh  = {n, {FRAC_BITS{1'b0}}};
    assign dx   = RW'(d_reg);
    assign r2   = {r_reg[RW-2:0], lo_reg[QB-1]};
    assign qbit = (r2 >= dx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        r_reg     <= RW'(nsh[NW-1:QB]);
                        lo_reg    <= nsh[QB-1:0];
                        d_reg     <= d;
                        state_reg <= D_CHK;
                    end
                end
                D_CHK:
                begin
                    if (r_reg >= dx)
                    begin
                        quot_reg  <= 32'h7FFF_FFFF;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    r_reg  <= qbit ? (r2 - dx) : r2;
                    lo_reg <= {lo_reg[QB-2:0], 1'b0};
                    q_reg  <= {q_reg[QB-2:0], qbit};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(QB - 1))
                    begin
                        quot_reg  <= {1'b0, q_reg[QB-2:0], qbit};
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

`default_nettype wire

/* rtl/ray_box_face_hit_top.sv */
// Ray / box-face hit top level: sequencer over the geometry table, the shared
// multiplier and the divider. Depends on rbfh_pkg, rbfh_cmd_if, rbfh_res_if,
// rbfh_table, rbfh_mul, rbfh_div.
//
// Usage:
//   cmd carries beats of two kinds. A load beat (kind 0) writes one table
//   word; addresses above 105 are dropped. A query beat (kind 1)
//   casts a ray and yields exactly one beat on res: hit, dist_sq, face_index.
//   cmd.ready is high only while the sequencer is idle.
//   A query fetches the matrix, then per face does a 15-word fetch, 63
//   products on the single multiplier and a divide, for each of the six
//   faces. Faces rejected early finish sooner. The multiplier turnaround and
//   the bit-serial divider set the query time.
//   The result sits in an output register; a new beat is accepted while it
//   waits, and a finished query holds until res is free.
//   Reset clears the sequencer and the output valid; the table contents are
//   undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_face_hit_top import rbfh_pkg::*; #(
    parameter int FACE_COUNT = 6,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rbfh_cmd_if.sink   cmd,
    rbfh_res_if.source res
);

    localparam logic signed [63:0] BEST_INIT = 64'sd1000000 <<< FRAC_BITS;
    localparam logic signed [63:0] HIT_LIMIT = 64'sd999999 <<< FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MRD, ST_FRD, ST_XF, ST_PL, ST_PCHK, ST_DIV,
        ST_ARC, ST_IN, ST_DS, ST_NEXT, ST_OUT
    } state_t;

    state_t            state_reg;
    logic [4:0]        cnt_reg;
    logic              ph_reg;
    logic [1:0]        j_reg;
    logic [1:0]        a_reg;
    logic [1:0]        c_reg;
    logic [2:0]        face_reg;
    logic              out_valid_reg;
    res_beat_t         out_reg;

    logic signed [31:0] o_reg   [3];
    logic signed [31:0] d_reg   [3];
    logic signed [31:0] m_reg   [MAT_WORDS];
    logic signed [31:0] fv_reg  [FACE_WORDS];
    logic signed [31:0] w_reg   [VERT_WORDS];
    logic signed [31:0] arc_reg [3];
    logic signed [31:0] t_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] num_reg;
    logic signed [63:0] den_reg;
    logic signed [63:0] best_reg;
    logic [2:0]         best_face_reg;

    logic               accept;
    logic               tbl_we;
    logic [6:0]         rd_addr;
    logic signed [31:0] rdata;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic               div_start;
    logic [63:0]        div_n;
    logic [63:0]        div_d;
    div_res_t           div_res;
    logic [6:0]         vbase;
    logic [6:0]         nbase;
    logic [1:0]         nx;
    logic signed [63:0] sum_xf;
    logic signed [63:0] sum_acc;
    logic               plane_go;
    logic               last_face;
    logic [3:0]         slot;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign tbl_we    = accept && (cmd.data.kind == KIND_LOAD)
                       && (cmd.data.table_addr < 7'(TABLE_DEPTH));

    assign vbase = 7'(VERT_BASE) + 7'(face_reg) * 7'd12;
    assign nbase = 7'(NORM_BASE) + 7'(face_reg) * 7'd3;
    assign nx    = j_reg + 2'd1;
    assign slot  = cnt_reg[3:0] - 4'd1;
    assign last_face = (face_reg == 3'(FACE_COUNT - 1));

    always_comb
    begin
        if (state_reg == ST_MRD)
        begin
            rd_addr = {3'b000, cnt_reg[3:0]};
        end
        else if (cnt_reg < 5'(VERT_WORDS))
        begin
            rd_addr = vbase + {2'b00, cnt_reg};
        end
        else
        begin
            rd_addr = nbase + {2'b00, cnt_reg} - 7'(VERT_WORDS);
        end
    end

    rbfh_table u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (cmd.data.table_addr),
        .wdata (cmd.data.table_value),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_XF:
            begin
                mul_a = m_reg[{c_reg, a_reg}];
                mul_b = fv_reg[idx3(j_reg, c_reg)];
            end
            ST_PL:
            begin
                mul_a = fv_reg[4'(VERT_WORDS) + {2'b00, a_reg}];
                case (c_reg)
                    2'd0:    mul_b = w_reg[{2'b00, a_reg}];
                    2'd1:    mul_b = o_reg[a_reg];
                    default: mul_b = d_reg[a_reg];
                endcase
            end
            ST_ARC:
            begin
                mul_a = t_reg;
                mul_b = d_reg[a_reg];
            end
            ST_IN:
            begin
                mul_a = sub_sat(arc_reg[a_reg], w_reg[idx3(j_reg, a_reg)]);
                mul_b = sub_sat(w_reg[idx3(nx, a_reg)], w_reg[idx3(j_reg, a_reg)]);
            end
            ST_DS:
            begin
                mul_a = sub_sat(arc_reg[a_reg], o_reg[a_reg]);
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rbfh_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign plane_go  = (den_reg != 64'sd0)
                       && (((num_reg > 64'sd0) && (den_reg > 64'sd0))
                           || ((num_reg < 64'sd0) && (den_reg < 64'sd0)));
    assign div_start = (state_reg == ST_PCHK) && plane_go;
    assign div_n     = (num_reg < 64'sd0) ? 64'(-num_reg) : 64'(num_reg);
    assign div_d     = (den_reg < 64'sd0) ? 64'(-den_reg) : 64'(den_reg);

    rbfh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .res   (div_res)
    );

    assign sum_xf  = ((c_reg == 2'd0) ? 64'(m_reg[{2'b11, a_reg}]) : acc_reg) + prod;
    assign sum_acc = ((a_reg == 2'd0) ? 64'sd0 : acc_reg) + prod;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ph_reg        <= 1'b0;
            j_reg         <= '0;
            a_reg         <= '0;
            c_reg         <= '0;
            face_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cmd.data.kind == KIND_QUERY))
                    begin
                        cnt_reg   <= '0;
                        face_reg  <= '0;
                        state_reg <= ST_MRD;
                    end
                end
                ST_MRD:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(MAT_WORDS))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FRD;
                    end
                end
                ST_FRD:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(FACE_WORDS))
                    begin
                        j_reg     <= '0;
                        a_reg     <= '0;
                        c_reg     <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= ST_XF;
                    end
                end
                ST_XF:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (c_reg != 2'd2)
                        begin
                            c_reg <= c_reg + 2'd1;
                        end
                        else
                        begin
                            c_reg <= '0;
                            if (a_reg != 2'd2)
                            begin
                                a_reg <= a_reg + 2'd1;
                            end
                            else
                            begin
                                a_reg <= '0;
                                j_reg <= j_reg + 2'd1;
                                if (j_reg == 2'd3)
                                begin
                                    state_reg <= ST_PL;
                                end
                            end
                        end
                    end
                end
                ST_PL:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (c_reg != 2'd2)
                        begin
                            c_reg <= c_reg + 2'd1;
                        end
                        else
                        begin
                            c_reg <= '0;
                            a_reg <= a_reg + 2'd1;
                            if (a_reg == 2'd2)
                            begin
                                a_reg     <= '0;
                                state_reg <= ST_PCHK;
                            end
                        end
                    end
                end
                ST_PCHK:
                begin
                    state_reg <= plane_go ? ST_DIV : ST_NEXT;
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        a_reg     <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= (div_res.quot == 32'd0) ? ST_NEXT : ST_ARC;
                    end
                end
                ST_ARC:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        a_reg <= a_reg + 2'd1;
                        if (a_reg == 2'd2)
                        begin
                            a_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= ST_IN;
                        end
                    end
                end
                ST_IN:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        a_reg <= a_reg + 2'd1;
                        if (a_reg == 2'd2)
                        begin
                            a_reg <= '0;
                            j_reg <= j_reg + 2'd1;
                            if (sum_acc < 64'sd0)
                            begin
                                state_reg <= ST_NEXT;
                            end
                            else if (j_reg == 2'd3)
                            begin
                                state_reg <= ST_DS;
                            end
                        end
                    end
                end
                ST_DS:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        a_reg <= a_reg + 2'd1;
                        if (a_reg == 2'd2)
                        begin
                            a_reg     <= '0;
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT:
                begin
                    cnt_reg <= '0;
                    if (last_face)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        face_reg  <= face_reg + 3'd1;
                        state_reg <= ST_FRD;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.data.kind == KIND_QUERY))
                begin
                    o_reg[0]      <= cmd.data.origin_x;
                    o_reg[1]      <= cmd.data.origin_y;
                    o_reg[2]      <= cmd.data.origin_z;
                    d_reg[0]      <= cmd.data.dir_x;
                    d_reg[1]      <= cmd.data.dir_y;
                    d_reg[2]      <= cmd.data.dir_z;
                    best_reg      <= BEST_INIT;
                    best_face_reg <= '0;
                end
            end
            ST_MRD:
            begin
                if (cnt_reg != 5'd0)
                begin
                    m_reg[slot] <= rdata;
                end
            end
            ST_FRD:
            begin
                if (cnt_reg != 5'd0)
                begin
                    fv_reg[slot] <= rdata;
                end
                num_reg <= '0;
                den_reg <= '0;
            end
            ST_XF:
            begin
                if (ph_reg)
                begin
                    acc_reg <= sum_xf;
                    if (c_reg == 2'd2)
                    begin
                        w_reg[idx3(j_reg, a_reg)] <= sat32(sum_xf);
                    end
                end
            end
            ST_PL:
            begin
                if (ph_reg)
                begin
                    case (c_reg)
                        2'd0:    num_reg <= num_reg + prod;
                        2'd1:    num_reg <= num_reg - prod;
                        default: den_reg <= den_reg + prod;
                    endcase
                end
            end
            ST_DIV:
            begin
                t_reg <= div_res.quot;
            end
            ST_ARC:
            begin
                if (ph_reg)
                begin
                    arc_reg[a_reg] <= sat32(64'(o_reg[a_reg]) + prod);
                end
            end
            ST_IN:
            begin
                if (ph_reg)
                begin
                    acc_reg <= sum_acc;
                end
            end
            ST_DS:
            begin
                if (ph_reg)
                begin
                    acc_reg <= sum_acc;
                    if ((a_reg == 2'd2) && (best_reg >= sum_acc))
                    begin
                        best_reg      <= sum_acc;
                        best_face_reg <= face_reg;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    if (best_reg >= HIT_LIMIT)
                    begin
                        out_reg <= '0;
                    end
                    else
                    begin
                        out_reg.hit        <= 1'b1;
                        out_reg.dist_sq    <= (best_reg > 64'(DIST_MAX)) ? DIST_MAX
                                                                        : best_reg[35:0];
                        out_reg.face_index <= best_face_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

endmodule

`default_nettype wire
